// ===== hw/rtl/esr_pkg.sv =====
// shared types and constants for the sign-activation elman step
// no dependencies
package esr_pkg;

  localparam int HiddenSizeDef  = 5;
  localparam int ContextSizeDef = 5;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_STEP   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        weight_index;
    logic signed [23:0] weight_value;
    logic signed [31:0] sample_in;
    logic signed [31:0] expected;
  } in_word_t;

  typedef struct packed {
    logic signed [1:0] predicted;
    logic [47:0]       error_total;
  } out_word_t;

  // control handed along the cell row
  typedef struct packed {
    logic clear;
    logic load_hidden;
    logic add;
    logic add_sign;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [23:0] w,
                                                 input logic pos);
    logic signed [33:0] s;
    logic signed [33:0] we;
    begin
      we = 34'(w);
      s = pos ? (34'(acc) + we) : (34'(acc) - we);
      if (s > 34'sh7fffffff) sat_add = 32'sh7fffffff;
      else if (s < -34'sh80000000) sat_add = 32'sh80000000;
      else sat_add = s[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/esr_ram.sv =====
// generic single-port ram, registered read
// no dependencies
module esr_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/esr_cell.sv =====
// one accumulator cell of the row; holds a sum and shifts it to its neighbor
// depends on esr_pkg
module esr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  esr_pkg::cell_ctl_t  ctl,
  input  logic                shift,
  input  logic signed [31:0]  prev_sum,
  input  logic signed [23:0]  weight,
  output logic signed [31:0]  sum
);
  logic signed [31:0] sum_r, sum_nxt;
  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) sum_nxt = '0;
    else if (ctl.add) sum_nxt = esr_pkg::sat_add(sum_r, weight, ctl.add_sign);
    else if (shift) sum_nxt = prev_sum;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) sum_r <= '0;
    else sum_r <= sum_nxt;
  end
  assign sum = sum_r;
endmodule

// ===== hw/rtl/esr_row.sv =====
// ring of accumulator cells; the head cell is the one being worked on
// depends on esr_pkg, esr_cell
module esr_row #(
  parameter int Size = esr_pkg::HiddenSizeDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  esr_pkg::cell_ctl_t ctl,
  input  logic               rotate,
  input  logic signed [23:0] weight,
  output logic signed [31:0] head
);
  logic signed [31:0] sums [Size];
  esr_pkg::cell_ctl_t hctl, octl;
  always_comb begin
    hctl = ctl;
    octl = ctl;
    octl.add = 1'b0;
  end
  // cell 0 is the head; rotation hands each sum down, head wraps to the tail
  for (genvar k = 0; k < Size; k++) begin : g_cell
    esr_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl(k == 0 ? hctl : octl),
      .shift(rotate),
      .prev_sum(sums[(k + 1) % Size]),
      .weight(weight),
      .sum(sums[k])
    );
  end
  assign head = sums[0];
endmodule

// ===== hw/rtl/elman_sign_rnn_step.sv =====
// top level of the sign-activation elman step
// depends on esr_pkg, esr_ram, esr_row
//
// words enter on in_valid/in_ready and results leave on out_valid/out_ready.
// a load word writes one weight into the weight ram, no result.
// a clear word zeroes context sums, hidden sums and error total, no result.
// loads and clears can follow back to back.
// a step word walks all 2H(C+1) weights (60 at default sizes) through the
// saturating adders in the head cells of two rotating rings, hidden and context,
// and an output sum adder; each weight is an add, then a rotation of a ring.
// in_ready stays low while a step runs; the result is registered and in_ready
// returns at the same edge. the ram read latency and the add-then-rotate cells
// set the pace of a step. when the receiver stalls, loads and clears are still
// taken while a result waits; a finished step holds in its last state, with
// in_ready low, until the output register frees.
// reset (synchronous, active low) clears sums, error total and out_valid;
// weights stay undefined until loaded.
module elman_sign_rnn_step #(
  parameter int HiddenSize  = esr_pkg::HiddenSizeDef,
  parameter int ContextSize = esr_pkg::ContextSizeDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  esr_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output esr_pkg::out_word_t out_data
);
  localparam int ChBase = HiddenSize;
  localparam int HcBase = ChBase + ContextSize * HiddenSize;
  localparam int HoBase = HcBase + HiddenSize * ContextSize;
  localparam int WCount = HoBase + HiddenSize;
  localparam int AW = $clog2(WCount);
  localparam int MaxSize = (HiddenSize > ContextSize) ? HiddenSize : ContextSize;
  localparam int CW = $clog2(MaxSize + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IH   = 3'd1;
  localparam logic [2:0] S_CH   = 3'd2;
  localparam logic [2:0] S_HC   = 3'd3;
  localparam logic [2:0] S_HO   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [AW-1:0] addr_r, addr_nxt;     // weight read address, read data valid the next cycle
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic ph_r, ph_nxt;                  // 0 add into the head or the output sum, 1 rotate
  logic x_pos_r, x_pos_nxt;
  logic signed [31:0] exp_r, exp_nxt;
  logic signed [31:0] osum_r, osum_nxt;
  logic [47:0] err_r, err_nxt;
  logic ov_r, ov_nxt;
  esr_pkg::out_word_t od_r, od_nxt;

  logic [23:0] wr;
  logic signed [31:0] h_head, c_head;
  esr_pkg::cell_ctl_t hctl, cctl;
  logic hrot, crot;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic accept;
  logic signed [33:0] dif;
  logic [32:0] mag;
  logic [48:0] esum;

  esr_ram #(.Width(24), .Depth(WCount)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_data.weight_value), .rdata(wr)
  );

  esr_row #(.Size(HiddenSize)) u_hid (
    .clk(clk), .rst_n(rst_n), .ctl(hctl), .rotate(hrot),
    .weight($signed(wr)), .head(h_head)
  );
  esr_row #(.Size(ContextSize)) u_ctx (
    .clk(clk), .rst_n(rst_n), .ctl(cctl), .rotate(crot),
    .weight($signed(wr)), .head(c_head)
  );

  assign in_ready = (st_r == S_IDLE);
  assign accept = in_valid && in_ready;

  // both rings sit at index 0 between steps; every row of adds ends with the
  // ring back at its start, so the other ring's single rotation lines up
  always_comb begin
    st_nxt = st_r; addr_nxt = addr_r; i_nxt = i_r; j_nxt = j_r; ph_nxt = ph_r;
    x_pos_nxt = x_pos_r; exp_nxt = exp_r; osum_nxt = osum_r; err_nxt = err_r;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    hctl = '0; cctl = '0; hrot = 1'b0; crot = 1'b0;
    ram_we = 1'b0; ram_addr = addr_r;
    dif = '0; mag = '0; esum = '0;

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.action)
            esr_pkg::ACT_LOAD: begin
              ram_addr = in_data.weight_index[AW-1:0];
              ram_we = (in_data.weight_index < 12'(WCount));
            end
            esr_pkg::ACT_CLEAR: begin
              hctl.clear = 1'b1; cctl.clear = 1'b1; err_nxt = '0;
            end
            esr_pkg::ACT_STEP: begin
              x_pos_nxt = in_data.sample_in > 0;
              exp_nxt = in_data.expected;
              hctl.clear = 1'b1; osum_nxt = '0;
              ram_addr = '0;
              st_nxt = S_IH; addr_nxt = '0; j_nxt = '0; i_nxt = '0; ph_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_IH: begin
        if (!ph_r) begin
          hctl.add = 1'b1; hctl.add_sign = x_pos_r;
          addr_nxt = addr_r + 1'b1; ph_nxt = 1'b1;
        end else begin
          hrot = 1'b1; ph_nxt = 1'b0;
          if (j_r == CW'(HiddenSize - 1)) begin
            j_nxt = '0; st_nxt = S_CH;
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_CH: begin
        // context i (head of context ring) steers hidden j
        if (!ph_r) begin
          hctl.add = 1'b1; hctl.add_sign = c_head > 0;
          addr_nxt = addr_r + 1'b1; ph_nxt = 1'b1;
        end else begin
          hrot = 1'b1; ph_nxt = 1'b0;
          if (j_r == CW'(HiddenSize - 1)) begin
            j_nxt = '0; crot = 1'b1;
            if (i_r == CW'(ContextSize - 1)) begin
              i_nxt = '0; st_nxt = S_HC;
            end else i_nxt = i_r + 1'b1;
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_HC: begin
        // hidden i (head of hidden ring) steers context j
        if (!ph_r) begin
          cctl.add = 1'b1; cctl.add_sign = h_head > 0;
          addr_nxt = addr_r + 1'b1; ph_nxt = 1'b1;
        end else begin
          crot = 1'b1; ph_nxt = 1'b0;
          if (j_r == CW'(ContextSize - 1)) begin
            j_nxt = '0; hrot = 1'b1;
            if (i_r == CW'(HiddenSize - 1)) begin
              i_nxt = '0; st_nxt = S_HO;
            end else i_nxt = i_r + 1'b1;
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_HO: begin
        if (!ph_r) begin
          osum_nxt = esr_pkg::sat_add(osum_r, $signed(wr), h_head > 0);
          addr_nxt = addr_r + 1'b1; ph_nxt = 1'b1;
        end else begin
          hrot = 1'b1; ph_nxt = 1'b0;
          if (i_r == CW'(HiddenSize - 1)) begin
            i_nxt = '0; st_nxt = S_FIN;
          end else i_nxt = i_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!ov_nxt) begin
          dif = (osum_r > 0 ? 34'sd65536 : -34'sd65536) - 34'(exp_r);
          mag = (dif < 0) ? 33'(-dif) : 33'(dif);
          esum = 49'(err_r) + 49'(mag);
          err_nxt = esum[48] ? 48'hffffffffffff : esum[47:0];
          od_nxt.predicted = osum_r > 0 ? 2'sd1 : -2'sd1;
          od_nxt.error_total = err_nxt;
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= 1'b0; ov_r <= 1'b0;
      err_r <= '0; osum_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ov_r <= ov_nxt;
      err_r <= err_nxt; osum_r <= osum_nxt;
    end
    addr_r <= addr_nxt; i_r <= i_nxt; j_r <= j_nxt;
    x_pos_r <= x_pos_nxt; exp_r <= exp_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

`ifndef SYNTHESIS
  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !ph_r) else $error("idle with rotate pending");
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r <= S_FIN) else $error("illegal state");
`endif
endmodule

// ===== bench/tb.sv =====
// testbench for elman_sign_rnn_step: directed table then random words, checked
// against an in-bench predictor of the sign-activation elman step
// depends on esr_pkg and the rtl of elman_sign_rnn_step
`timescale 1ns / 1ps
module tb;

  localparam int HN = esr_pkg::HiddenSizeDef;
  localparam int CN = esr_pkg::ContextSizeDef;
  localparam int CH_B = HN;
  localparam int HC_B = CH_B + CN * HN;
  localparam int HO_B = HC_B + HN * CN;
  localparam int WCOUNT = HO_B + HN;
  localparam int N_RANDOM = 1716;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [47:0] ERR_TOP = 48'hffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  esr_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  esr_pkg::out_word_t out_data;

  elman_sign_rnn_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [23:0] weights[WCOUNT];
  logic signed [31:0] ctx[CN];
  logic signed [31:0] hid[HN];
  logic [47:0] err_acc;
  esr_pkg::out_word_t pending_results[$];

  int fails = 0;
  bit calm = 0;       // no idling at the end of the run
  bit hold_long = 0;  // receiver hold-off request
  int idle_watch = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic logic signed [31:0] sat_step(input logic signed [31:0] acc,
                                                  input logic signed [23:0] w,
                                                  input logic signed [31:0] act);
    longint s;
    s = (act > 0) ? longint'(acc) + longint'(w) : longint'(acc) - longint'(w);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  task automatic predict_word(input esr_pkg::in_word_t w);
    logic signed [31:0] osum;
    longint diff;
    logic [47:0] mag;
    esr_pkg::out_word_t r;
    osum = 0;
    case (w.action)
      esr_pkg::ACT_LOAD: begin
        if (w.weight_index < WCOUNT) weights[w.weight_index] = w.weight_value;
      end
      esr_pkg::ACT_CLEAR: begin
        foreach (ctx[i]) ctx[i] = 0;
        foreach (hid[i]) hid[i] = 0;
        err_acc = 0;
      end
      esr_pkg::ACT_STEP: begin
        for (int j = 0; j < HN; j++) hid[j] = sat_step(0, weights[j], w.sample_in);
        for (int i = 0; i < CN; i++)
          for (int j = 0; j < HN; j++)
            hid[j] = sat_step(hid[j], weights[CH_B + i * HN + j], ctx[i]);
        for (int i = 0; i < HN; i++)
          for (int j = 0; j < CN; j++)
            ctx[j] = sat_step(ctx[j], weights[HC_B + i * CN + j], hid[i]);
        for (int i = 0; i < HN; i++) osum = sat_step(osum, weights[HO_B + i], hid[i]);
        diff = ((osum > 0) ? 64'sd65536 : -64'sd65536) - longint'(w.expected);
        if (diff < 0) diff = -diff;
        mag = diff[47:0];
        if (mag > ERR_TOP - err_acc) err_acc = ERR_TOP;
        else err_acc = err_acc + mag;
        r.predicted = (osum > 0) ? 2'sd1 : -2'sd1;
        r.error_total = err_acc;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // one word through the input handshake, with random idle bursts before it
  task automatic send_word(input esr_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
  endtask

  function automatic esr_pkg::in_word_t mk(input logic [1:0] a, input int idx, input int wv,
                                           input int x, input int e);
    esr_pkg::in_word_t w;
    w.action = a;
    w.weight_index = idx[11:0];
    w.weight_value = wv[23:0];
    w.sample_in = x;
    w.expected = e;
    return w;
  endfunction

  function automatic esr_pkg::in_word_t rand_load(input bit any_index);
    int wv;
    wv = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32'h7fffff : 32'hff800000)
                                   : int'($urandom);
    return mk(esr_pkg::ACT_LOAD,
              any_index ? $urandom_range(0, 4095) : $urandom_range(0, WCOUNT - 1),
              wv, 0, 0);
  endfunction

  function automatic esr_pkg::in_word_t rand_step();
    int x;
    int e;
    x = int'($urandom);
    e = int'($urandom);
    case ($urandom_range(0, 5))
      0: x = 0;
      1: e = 32'h8000_0000;
      2: e = 32'h7fff_ffff;
      3: e = ($urandom_range(0, 1)) ? 65536 : -65536;
      default: ;
    endcase
    return mk(esr_pkg::ACT_STEP, $urandom_range(0, 4095), int'($urandom), x, e);
  endfunction

  // receiver: random stalls, checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    esr_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.predicted !== want.predicted)
          report("predicted", out_data.predicted, want.predicted);
        if (out_data.error_total !== want.error_total)
          report("error_total", out_data.error_total, want.error_total);
      end
    end
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_watch <= 0;
    else idle_watch <= idle_watch + 1;
    if (idle_watch >= WATCH_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  esr_pkg::in_word_t dir_words[$];

  initial begin
    int k;
    foreach (ctx[i]) ctx[i] = 0;
    foreach (hid[i]) hid[i] = 0;
    foreach (weights[i]) weights[i] = 0;
    err_acc = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every weight written first so no unwritten read happens
    for (int i = 0; i < WCOUNT; i++) dir_words.push_back(mk(esr_pkg::ACT_LOAD, i, 0, 0, 0));
    // out of range, ignored
    dir_words.push_back(mk(esr_pkg::ACT_LOAD, WCOUNT, 24'h7fffff, 0, 0));
    dir_words.push_back(mk(esr_pkg::ACT_LOAD, 4095, 24'h800000, 0, 0));
    // all zero weights: output sum zero gives -1
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 0, 0, 0, -65536));
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 4095, 0, 32'h7fffffff, 32'h7fffffff));
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 0, 0, 32'h80000000, 32'h80000000));
    dir_words.push_back(mk(esr_pkg::ACT_UNUSED, 5, 5, 5, 5));
    dir_words.push_back(mk(esr_pkg::ACT_CLEAR, 0, 0, 0, 0));
    dir_words.push_back(mk(esr_pkg::ACT_LOAD, 0, 24'h7fffff, 0, 0));
    dir_words.push_back(mk(esr_pkg::ACT_LOAD, HO_B, 24'h7fffff, 0, 0));
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 0, 0, 1, 65536));
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 0, 0, -1, 0));
    dir_words.push_back(mk(esr_pkg::ACT_LOAD, HC_B, 24'h800000, 0, 0));
    dir_words.push_back(mk(esr_pkg::ACT_STEP, 0, 0, 32'h7fffffff, 32'h80000000));
    dir_words.push_back(mk(esr_pkg::ACT_CLEAR, 0, 0, 0, 0));
    foreach (dir_words[i]) send_word(dir_words[i]);

    // random weights everywhere, then mostly steps with some reloads and clears
    for (int i = 0; i < WCOUNT; i++) send_word(rand_load(0));
    for (k = 0; k < N_RANDOM; k++) begin
      int pick;
      if (k == 300) hold_long = 1;
      if (k == N_RANDOM - 200) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 70) send_word(rand_step());
      else if (pick < 88) send_word(rand_load(pick < 86 ? 0 : 1));
      else if (pick < 93)
        send_word(mk(esr_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom));
      else if (pick < 95)
        send_word(mk(esr_pkg::ACT_UNUSED, $urandom, $urandom, $urandom, $urandom));
      else begin
        // drive large errors into the error total: expected at its most negative, no clear
        send_word(mk(esr_pkg::ACT_STEP, 0, 0, int'($urandom), 32'h80000000));
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== elman_sign_rnn_step.f =====
hw/rtl/esr_pkg.sv
hw/rtl/esr_ram.sv
hw/rtl/esr_cell.sv
hw/rtl/esr_row.sv
hw/rtl/elman_sign_rnn_step.sv
bench/tb.sv
